// ===== design/open_addressing_hash_set_assert.svh =====
// Assertion macros used by the hash set top level.
`ifndef OPEN_ADDRESSING_HASH_SET_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_SET_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OAHS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash set assertion failed");

// Next-cycle implication, disabled during reset.
`define OAHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash set assertion failed");

`endif

// ===== design/oahs_pkg.sv =====
// Package with types and constants of the open-addressing hash set.
`timescale 1ns / 1ps
package oahs_pkg;

  // Default parameter values.
  localparam int MAX_SLOTS_LOG2_DEF  = 10;
  localparam int INIT_SLOTS_LOG2_DEF = 3;
  localparam int KEY_WIDTH_DEF       = 32;

  // Configuration register resets and indexes.
  localparam logic [31:0] HASH_MULT_RESET = 32'd2654435769;
  localparam logic [8:0]  LOAD_THR_RESET  = 9'd179;
  localparam logic        REG_HASH_MULT   = 1'b0;
  localparam logic        REG_LOAD_THR    = 1'b1;

  // Slot marks as held in the mark memory.
  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_FILLED  = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_HASH,
    S_HOME,
    S_RD,
    S_CHK,
    S_ACT,
    S_PLACE,
    S_DEL,
    S_LOAD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RB_NEXT,
    S_RB_KEY,
    S_RESP
  } state_t;

endpackage

// ===== design/oahs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module oahs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/open_addressing_hash_set.sv =====
// Top level of the open-addressing hash set with a multiplicative hash.
`timescale 1ns / 1ps
// Usage: a request transaction (opcode, key) enters on req_valid/req_ready and
// yields exactly one response transaction (found, live_count, status) on
// rsp_valid/rsp_ready. Opcodes: insert, remove, contains, clear.
// One request is handled at a time; req_ready is high only while the block idles.
// Steps: the key is hashed by one shared 32x32 multiplier into a registered
// product, then the home slot is registered; each probe reads the mark and key
// memories, which have registered reads, and checks the slot; an act step
// follows, plus a place step and a load check for an insert that places a key,
// or a delete step for a remove that hits.
// Clear sweeps every slot of the mark memory: 2^MAX_SLOTS_LOG2 slots (1024 by default).
// An insert that reaches the load threshold rebuilds the table: it collects the
// keys from each slot of the old size, sweeps all 2^MAX_SLOTS_LOG2 mark slots, then
// runs a full insert search for each kept key; input is stalled meanwhile.
// Reset: a clearing pass over all 2^MAX_SLOTS_LOG2 slots runs before req_ready
// rises; configuration writes are taken during it.
// A stalled receiver holds the response in its output register; the next request
// is taken after the response transaction completes.
// Configuration: APB-style port, hash_multiplier at 0x0, load_threshold at 0x4.
module open_addressing_hash_set
  import oahs_pkg::*;
#(
  parameter int MAX_SLOTS_LOG2  = MAX_SLOTS_LOG2_DEF,
  parameter int INIT_SLOTS_LOG2 = INIT_SLOTS_LOG2_DEF,
  parameter int KEY_WIDTH       = KEY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  opcode,
  input  logic signed [KEY_WIDTH-1:0] key,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic                        found,
  output logic [MAX_SLOTS_LOG2:0]     live_count,
  output logic                        status
);

`include "open_addressing_hash_set_assert.svh"

  localparam int AW    = MAX_SLOTS_LOG2;
  localparam int CW    = MAX_SLOTS_LOG2 + 1;
  localparam int SLW   = $clog2(MAX_SLOTS_LOG2 + 1);
  localparam int CMP_W = CW + 9;
  localparam int DEPTH = 1 << MAX_SLOTS_LOG2;

  state_t state, state_next;

  logic [31:0]                 hash_multiplier;
  logic [8:0]                  load_threshold;
  logic                        boot;
  logic                        rebuilding;
  opcode_t                     op_r;
  logic signed [KEY_WIDTH-1:0] key_r;
  logic [31:0]                 prod_r;
  logic [AW-1:0]               home_r;
  logic [AW-1:0]               p_r;
  logic [AW:0]                 k_r;
  logic                        free_ok;
  logic                        free_empty;
  logic [AW-1:0]               free_pos;
  logic                        hit_r;
  logic [AW-1:0]               hit_pos;
  logic                        found_r;
  logic                        status_r;
  logic [CW-1:0]               stored_count;
  logic [CW-1:0]               used_count;
  logic [SLW-1:0]              size_log2;
  logic [AW:0]                 idx;
  logic [CW-1:0]               buf_n;
  logic [CW-1:0]               rb_i;

  // Memory ports.
  logic                 mark_we;
  logic [AW-1:0]        mark_waddr;
  mark_t                mark_wdata;
  logic [1:0]           mark_rdata;
  logic                 keys_we;
  logic [AW-1:0]        slot_raddr;
  logic [KEY_WIDTH-1:0] key_rdata;
  logic                 buf_we;
  logic [KEY_WIDTH-1:0] buf_rdata;

  // Derived values.
  logic [AW:0]    size_full;
  logic [AW-1:0]  size_mask;
  logic [63:0]    key_ext;
  logic [31:0]    hash_in;
  logic [31:0]    home_full;
  logic [5:0]     home_shift;
  mark_t          mark_rd;
  logic           slot_filled;
  logic           slot_match;
  logic           chain_end;
  logic           over_load;
  logic [CMP_W-1:0] load_lhs;
  logic [CMP_W-1:0] load_rhs;
  logic           cfg_wr;

  assign size_full  = (AW + 1)'(1) << size_log2;
  assign size_mask  = AW'(size_full - (AW + 1)'(1));
  assign key_ext    = 64'(key_r);
  assign hash_in    = key_ext[31:0];
  assign home_shift = 6'd32 - 6'(size_log2);
  assign home_full  = prod_r >> home_shift;

  // Decode of the slot returned by the memories.
  always_comb begin
    case (mark_rdata)
      MARK_EMPTY:   mark_rd = MARK_EMPTY;
      MARK_FILLED:  mark_rd = MARK_FILLED;
      MARK_DELETED: mark_rd = MARK_DELETED;
      default:      mark_rd = MARK_DELETED;
    endcase
  end
  assign slot_filled = (mark_rd == MARK_FILLED);
  assign slot_match  = slot_filled && (key_rdata == key_r);
  assign chain_end   = (mark_rd == MARK_EMPTY) || (k_r == size_full - (AW + 1)'(1));

  // Load check: used_count * 256 against load_threshold << size_log2.
  assign load_lhs  = CMP_W'(used_count) << 8;
  assign load_rhs  = CMP_W'(load_threshold) << size_log2;
  assign over_load = (load_lhs >= load_rhs);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[2])
      REG_HASH_MULT: prdata = hash_multiplier;
      REG_LOAD_THR:  prdata = 32'(load_threshold);
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_multiplier <= HASH_MULT_RESET;
      load_threshold  <= LOAD_THR_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_HASH_MULT: hash_multiplier <= pwdata;
        REG_LOAD_THR:  load_threshold  <= pwdata[8:0];
        default:       hash_multiplier <= hash_multiplier;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory controls.
  always_comb begin
    state_next = state;
    mark_we    = 1'b0;
    mark_waddr = idx[AW-1:0];
    mark_wdata = MARK_EMPTY;
    keys_we    = 1'b0;
    buf_we     = 1'b0;
    slot_raddr = p_r;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    case (state)
      S_CLR: begin
        mark_we = 1'b1;
        if (idx[AW-1:0] == '1) begin
          if (boot) begin
            state_next = S_IDLE;
          end else if (rebuilding) begin
            state_next = S_RB_NEXT;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = (opcode == OP_CLEAR) ? S_CLR : S_HASH;
        end
      end
      S_HASH: state_next = S_HOME;
      S_HOME: state_next = S_RD;
      S_RD:   state_next = S_CHK;
      S_CHK: begin
        if (slot_match || chain_end) begin
          state_next = S_ACT;
        end else begin
          state_next = S_RD;
        end
      end
      S_ACT: begin
        case (op_r)
          OP_INSERT: begin
            if (!hit_r && free_ok) begin
              state_next = S_PLACE;
            end else begin
              state_next = rebuilding ? S_RB_NEXT : S_RESP;
            end
          end
          OP_REMOVE: state_next = hit_r ? S_DEL : S_RESP;
          default:   state_next = S_RESP;
        endcase
      end
      S_PLACE: begin
        mark_we    = 1'b1;
        mark_waddr = free_pos;
        mark_wdata = MARK_FILLED;
        keys_we    = 1'b1;
        state_next = rebuilding ? S_RB_NEXT : S_LOAD;
      end
      S_DEL: begin
        mark_we    = 1'b1;
        mark_waddr = hit_pos;
        mark_wdata = MARK_DELETED;
        state_next = S_RESP;
      end
      S_LOAD: state_next = over_load ? S_SCAN_RD : S_RESP;
      S_SCAN_RD: begin
        slot_raddr = idx[AW-1:0];
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        buf_we     = slot_filled;
        state_next = (idx[AW-1:0] == size_mask) ? S_CLR : S_SCAN_RD;
      end
      S_RB_NEXT: state_next = (rb_i == buf_n) ? S_RESP : S_RB_KEY;
      S_RB_KEY:  state_next = S_HASH;
      S_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      boot         <= 1'b1;
      rebuilding   <= 1'b0;
      idx          <= '0;
      stored_count <= '0;
      used_count   <= '0;
      size_log2    <= SLW'(INIT_SLOTS_LOG2);
      buf_n        <= '0;
      rb_i         <= '0;
    end else begin
      case (state)
        S_CLR: begin
          if (idx[AW-1:0] == '1) begin
            idx  <= '0;
            boot <= 1'b0;
            rb_i <= '0;
          end else begin
            idx <= idx + (AW + 1)'(1);
          end
        end
        S_IDLE: begin
          if (req_valid && (opcode == OP_CLEAR)) begin
            stored_count <= '0;
            used_count   <= '0;
            idx          <= '0;
          end
        end
        S_PLACE: begin
          stored_count <= stored_count + CW'(1);
          if (free_empty) begin
            used_count <= used_count + CW'(1);
          end
        end
        S_DEL: stored_count <= stored_count - CW'(1);
        S_LOAD: begin
          if (over_load) begin
            rebuilding <= 1'b1;
            idx        <= '0;
            buf_n      <= '0;
          end
        end
        S_SCAN_CHK: begin
          if (slot_filled) begin
            buf_n <= buf_n + CW'(1);
          end
          if (idx[AW-1:0] == size_mask) begin
            idx          <= '0;
            stored_count <= '0;
            used_count   <= '0;
            if (size_log2 < SLW'(MAX_SLOTS_LOG2)) begin
              size_log2 <= size_log2 + SLW'(1);
            end
          end else begin
            idx <= idx + (AW + 1)'(1);
          end
        end
        S_RB_NEXT: begin
          if (rb_i == buf_n) begin
            rebuilding <= 1'b0;
          end
        end
        S_RB_KEY: rb_i <= rb_i + CW'(1);
        default: idx <= idx;
      endcase
    end
  end

  // Request and search datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_r     <= opcode_t'(opcode);
          key_r    <= key;
          found_r  <= 1'b0;
          status_r <= 1'b0;
        end
      end
      S_RB_KEY: begin
        op_r  <= OP_INSERT;
        key_r <= buf_rdata;
      end
      S_HASH: prod_r <= 32'(hash_in * hash_multiplier);
      S_HOME: begin
        home_r  <= home_full[AW-1:0];
        p_r     <= home_full[AW-1:0];
        k_r     <= '0;
        hit_r   <= 1'b0;
        free_ok <= 1'b0;
      end
      S_CHK: begin
        if (slot_match) begin
          hit_r   <= 1'b1;
          hit_pos <= p_r;
        end else if (!slot_filled && !free_ok) begin
          free_ok    <= 1'b1;
          free_pos   <= p_r;
          free_empty <= (mark_rd == MARK_EMPTY);
        end
        p_r <= (p_r + home_r) & size_mask;
        k_r <= k_r + (AW + 1)'(1);
      end
      S_ACT: begin
        if (!rebuilding) begin
          case (op_r)
            OP_INSERT: begin
              found_r  <= hit_r;
              status_r <= !hit_r && !free_ok;
            end
            OP_CONTAINS: found_r <= hit_r;
            default:     found_r <= 1'b0;
          endcase
        end
      end
      S_DEL: found_r <= 1'b1;
      default: prod_r <= prod_r;
    endcase
  end

  // Response fields.
  assign found      = found_r;
  assign status     = status_r;
  assign live_count = stored_count;

  // Slot marks.
  oahs_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (slot_raddr),
    .rdata (mark_rdata)
  );

  // Slot keys.
  oahs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_keys (
    .clk   (clk),
    .we    (keys_we),
    .waddr (free_pos),
    .wdata (key_r),
    .raddr (slot_raddr),
    .rdata (key_rdata)
  );

  // Rebuild buffer of collected keys.
  oahs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_rebuild (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_n[AW-1:0]),
    .wdata (key_rdata),
    .raddr (rb_i[AW-1:0]),
    .rdata (buf_rdata)
  );

  // Assertions.
  `OAHS_ASSERT_NOW(a_stored_le_used, 1'b1, stored_count <= used_count)
  `OAHS_ASSERT_NOW(a_used_le_size, 1'b1, (AW + 1)'(used_count) <= size_full)
  `OAHS_ASSERT_NEXT(a_clear_zero, req_valid && req_ready && (opcode == OP_CLEAR),
                    (stored_count == '0) && (used_count == '0))
  `OAHS_ASSERT_NOW(a_size_range, 1'b1,
                   (size_log2 >= SLW'(INIT_SLOTS_LOG2)) && (size_log2 <= SLW'(MAX_SLOTS_LOG2)))

endmodule

// ===== tb/sv/open_addressing_hash_set_checker.sv =====
// Checker that predicts and compares every response of the hash set.
`timescale 1ns / 1ps
module open_addressing_hash_set_checker
  import oahs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic        found,
  input  logic [10:0] live_count,
  input  logic        status,
  output int          errors,
  output int          pending
);

  localparam int SLOT_CAP = 1 << MAX_SLOTS_LOG2_DEF;

  typedef struct packed {
    logic        found;
    logic [10:0] live_count;
    logic        status;
  } set_reply_t;

  // Mirror of the table and its configuration.
  logic [31:0] slot_key [SLOT_CAP];
  mark_t       slot_mark [SLOT_CAP];
  logic [31:0] moved_keys [SLOT_CAP];
  int          stored_keys;
  int          used_slots;
  int          table_log2;
  logic [31:0] mult_reg;
  logic [8:0]  thresh_reg;
  set_reply_t  reply_q [$];

  // Walks the probe chain of a key; reports a hit or the first free slot.
  function automatic bit probe_chain(input logic [31:0] k, output int hit,
                                     output int free_pos, output bit free_ok);
    int          sz;
    int          home;
    int          p;
    logic [31:0] frac;
    sz = 1 << table_log2;
    frac = k * mult_reg;
    home = int'(frac >> (32 - table_log2));
    hit = 0;
    free_pos = 0;
    free_ok = 0;
    for (int i = 0; i < sz; i++) begin
      p = (home * (i + 1)) & (sz - 1);
      if (slot_mark[p] == MARK_FILLED && slot_key[p] == k) begin
        hit = p;
        return 1'b1;
      end
      if (slot_mark[p] != MARK_FILLED && !free_ok) begin
        free_pos = p;
        free_ok = 1'b1;
      end
      if (slot_mark[p] == MARK_EMPTY) break;
    end
    return 1'b0;
  endfunction

  function automatic void fill_slot(input int p, input logic [31:0] k);
    if (slot_mark[p] == MARK_EMPTY) used_slots++;
    slot_key[p] = k;
    slot_mark[p] = MARK_FILLED;
    stored_keys++;
  endfunction

  function automatic void wipe_marks();
    foreach (slot_mark[i]) slot_mark[i] = MARK_EMPTY;
    stored_keys = 0;
    used_slots = 0;
  endfunction

  // Grows the table (or keeps it at the top size) and reinserts the live keys.
  function automatic void grow_table();
    int n;
    int hit;
    int fpos;
    bit fok;
    n = 0;
    for (int i = 0; i < (1 << table_log2); i++)
      if (slot_mark[i] == MARK_FILLED) begin
        moved_keys[n] = slot_key[i];
        n++;
      end
    if (table_log2 < MAX_SLOTS_LOG2_DEF) table_log2++;
    wipe_marks();
    for (int i = 0; i < n; i++)
      if (!probe_chain(moved_keys[i], hit, fpos, fok) && fok)
        fill_slot(fpos, moved_keys[i]);
  endfunction

  function automatic set_reply_t apply_request(input opcode_t op, input logic [31:0] k);
    set_reply_t r;
    int         hit;
    int         fpos;
    bit         fok;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (probe_chain(k, hit, fpos, fok)) begin
          r.found = 1'b1;
        end else if (!fok) begin
          r.status = 1'b1;
        end else begin
          fill_slot(fpos, k);
          if (longint'(used_slots) * 256 >= (longint'(thresh_reg) << table_log2))
            grow_table();
        end
      end
      OP_REMOVE: begin
        if (probe_chain(k, hit, fpos, fok)) begin
          slot_mark[hit] = MARK_DELETED;
          stored_keys--;
          r.found = 1'b1;
        end
      end
      OP_CONTAINS: r.found = probe_chain(k, hit, fpos, fok);
      default: wipe_marks();
    endcase
    r.live_count = 11'(stored_keys);
    return r;
  endfunction

  // Track configuration writes, predict on requests, compare on responses.
  always @(posedge clk) begin
    set_reply_t want;
    if (rst) begin
      wipe_marks();
      table_log2 = INIT_SLOTS_LOG2_DEF;
      mult_reg = HASH_MULT_RESET;
      thresh_reg = LOAD_THR_RESET;
      reply_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LOAD_THR) thresh_reg = pwdata[8:0];
        else mult_reg = pwdata;
      end
      if (rsp_valid && rsp_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: response transaction with no request waiting", $realtime);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $realtime, want.found, found);
            errors++;
          end
          if (live_count !== want.live_count) begin
            $display("%0t: live_count expected %0d actual %0d", $realtime,
                     want.live_count, live_count);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, status);
            errors++;
          end
        end
      end
      if (req_valid && req_ready)
        reply_q.insert(reply_q.size(), apply_request(opcode_t'(opcode), key));
    end
    pending = reply_q.size();
  end

endmodule

// ===== tb/sv/open_addressing_hash_set_test.sv =====
// Top of the hash set testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module open_addressing_hash_set_test;
  import oahs_pkg::*;

  localparam int STALL_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  opcode = OP_CONTAINS;
  logic [31:0] key = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic        found;
  logic [10:0] live_count;
  logic        status;
  int          errors;
  int          pending;

  // Traffic shaping shared with the receiver.
  bit          quiet_mode = 1'b0;
  bit          long_hold = 1'b0;
  int          hold_left = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [31:0] key_pool [$];

  always #4 clk = ~clk;

  open_addressing_hash_set u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_valid, .req_ready, .opcode, .key(key),
    .rsp_valid, .rsp_ready, .found, .live_count, .status
  );

  open_addressing_hash_set_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .req_valid, .req_ready, .opcode, .key, .rsp_valid, .rsp_ready,
    .found, .live_count, .status, .errors, .pending
  );

  // Receiver: random stalls, a quiet stretch, or one long hold-off on request.
  always @(posedge clk) begin
    if (long_hold) begin
      long_hold = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (quiet_mode) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on cycles with no transaction at all.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** open_addressing_hash_set: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one request transaction and waits for it to be taken.
  task automatic send(input opcode_t op, input logic [31:0] k);
    req_valid <= 1'b1;
    opcode <= op;
    key <= k;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (op == OP_INSERT && key_pool.size() < 64) key_pool.insert(key_pool.size(), k);
    if (burst_left == 0 && !quiet_mode) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom;
  endfunction

  // Random mix: mostly inserts and lookups, some removes, rare clears.
  task automatic random_items(input int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) send(OP_INSERT, pick_key());
      else if (roll < 65) send(OP_REMOVE, pick_key());
      else if (roll < 98) send(OP_CONTAINS, pick_key());
      else begin
        send(OP_CLEAR, $urandom);
        key_pool.delete();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: key extremes, duplicates, tombstones and clear.
    quiet_mode = 1'b1;
    send(OP_INSERT, 32'h0000_0000);
    send(OP_INSERT, 32'h8000_0000);
    send(OP_INSERT, 32'h7FFF_FFFF);
    send(OP_INSERT, 32'hFFFF_FFFF);
    send(OP_INSERT, 32'h7FFF_FFFF);
    send(OP_CONTAINS, 32'h8000_0000);
    send(OP_CONTAINS, 32'h0000_0001);
    send(OP_REMOVE, 32'hFFFF_FFFF);
    send(OP_REMOVE, 32'hFFFF_FFFF);
    send(OP_CONTAINS, 32'hFFFF_FFFF);
    send(OP_INSERT, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send(OP_INSERT, 32'h1234_0000 + i);
    send(OP_CONTAINS, 32'h1234_0005);
    send(OP_CLEAR, 32'h5555_AAAA);
    send(OP_CONTAINS, 32'h0000_0000);
    quiet_mode = 1'b0;
    key_pool.delete();
    drain();

    random_items(150);

    // Long receiver hold-off while requests keep coming.
    long_hold = 1'b1;
    quiet_mode = 1'b1;
    random_items(12);
    quiet_mode = 1'b0;
    drain();
    random_items(30);
    drain();

    // Threshold at 256: grows only when every slot is used.
    write_reg(REG_LOAD_THR, 32'd256);
    write_reg(REG_HASH_MULT, 32'hFFFF_FFFF);
    random_items(140);
    drain();

    // A zero multiplier sends every key home to slot zero with a zero probe step: only slot zero holds keys.
    send(OP_CLEAR, 32'h0);
    drain();
    write_reg(REG_HASH_MULT, 32'h0000_0000);
    write_reg(REG_LOAD_THR, 32'd200);
    random_items(60);
    drain();

    // Threshold of one: new slots rebuild the table often, up to the largest table.
    send(OP_CLEAR, 32'h0);
    drain();
    write_reg(REG_HASH_MULT, 32'h0000_0001);
    write_reg(REG_LOAD_THR, 32'd1);
    random_items(80);
    drain();

    // Back to the reset setting with a busy mix.
    write_reg(REG_HASH_MULT, HASH_MULT_RESET);
    write_reg(REG_LOAD_THR, 32'(LOAD_THR_RESET));
    random_items(200);
    drain();
    write_reg(REG_LOAD_THR, 32'd64);
    random_items(150);
    drain();
    repeat (50) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("** open_addressing_hash_set: PASSED **");
    end else begin
      $display("** open_addressing_hash_set: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/oahs_pkg.sv
design/oahs_ram.sv
design/open_addressing_hash_set.sv
tb/sv/open_addressing_hash_set_checker.sv
tb/sv/open_addressing_hash_set_test.sv
